// File: sv/usr_pkg.sv
// shared constants, register codes and control types of the sweep ranger
package usr_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;

    localparam int STEP_W   = 13;
    localparam int END_W    = 16;
    localparam int SETTLE_W = 20;
    localparam int TRIG_W   = 10;
    localparam int HDUTY_W  = 15;
    localparam int HWAIT_W  = 22;
    localparam int SCALE_W  = 16;
    localparam int WRAP_W   = 16;

    localparam int ANGLE_W = 16;
    localparam int LEVEL_W = 16;
    localparam int DIST_W  = 15;
    localparam int COUNT_W = 16;
    localparam int WAIT_W  = 22;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_END  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_DUTY  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_WAIT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_SCALE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_WRAP   = 3'd7;

    localparam int STEP_RST   = 366;
    localparam int END_RST    = 30720;
    localparam int SETTLE_RST = 14000;
    localparam int TRIG_RST   = 10;
    localparam int HDUTY_RST  = 400;
    localparam int HWAIT_RST  = 500000;
    localparam int SCALE_RST  = 3413;
    localparam int WRAP_RST   = 39062;

    localparam int SERVO_PERIOD_US = 20000;

    localparam logic [LEVEL_W-1:0] HOME_LEVEL_RST =
        LEVEL_W'(HDUTY_RST * WRAP_RST / SERVO_PERIOD_US);

    // floor(x / period) for 32-bit x as (x * LVL_MUL) >> LVL_SHIFT
    localparam int LVL_SHIFT = 32 + $clog2(SERVO_PERIOD_US);
    localparam int LVL_MUL_W = 33;
    localparam longint unsigned LVL_MUL_L =
        ((64'd1 << LVL_SHIFT) + 64'(SERVO_PERIOD_US) - 64'd1) / 64'(SERVO_PERIOD_US);
    localparam logic [LVL_MUL_W-1:0] LVL_MUL = LVL_MUL_L[LVL_MUL_W-1:0];

    // count * 8 / 29 as (count * 8 * DIST_MUL) >> DIST_SHIFT
    localparam int DIST_DIV   = 29;
    localparam int DIST_SHIFT = 24;
    localparam int DIST_MUL_W = 20;
    localparam logic [DIST_MUL_W-1:0] DIST_MUL =
        DIST_MUL_W'(((1 << DIST_SHIFT) + DIST_DIV - 1) / DIST_DIV);

    localparam logic [2:0] PH_HOME   = 3'd0;
    localparam logic [2:0] PH_SETTLE = 3'd1;
    localparam logic [2:0] PH_TRIG   = 3'd2;
    localparam logic [2:0] PH_RISE   = 3'd3;
    localparam logic [2:0] PH_COUNT  = 3'd4;

    typedef struct packed {
        logic accept;
        logic eval;
        logic lv_load;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic lv_req;
        logic out_free;
    } t_sts;

endpackage

// File: sv/usr_in_if.sv
// input channel: one echo pin sample per item
interface usr_in_if;
    logic valid;
    logic ready;
    logic echo_level;

    modport src (output valid, output echo_level, input ready);
    modport snk (input valid, input echo_level, output ready);
endinterface

// File: sv/usr_out_if.sv
// output channel: trigger, servo level and distance sample per item
interface usr_out_if;
    logic                       valid;
    logic                       ready;
    logic                       trigger_out;
    logic [usr_pkg::LEVEL_W-1:0] pwm_level;
    logic                       sample_valid;
    logic [usr_pkg::ANGLE_W-1:0] angle_q8;
    logic [usr_pkg::DIST_W-1:0]  distance_q4;
    logic                       sweep_last;

    modport src (output valid, output trigger_out, output pwm_level, output sample_valid,
                 output angle_q8, output distance_q4, output sweep_last, input ready);
    modport snk (input valid, input trigger_out, input pwm_level, input sample_valid,
                 input angle_q8, input distance_q4, input sweep_last, output ready);
endinterface

// File: sv/ultrasonic_sweep_ranger.sv
// top level of the servo sweep ultrasonic ranger
//
// i_item carries one echo pin sample per item, one item per microsecond tick.
// o_res returns exactly one result item per input item: trigger drive, servo
// pwm compare level in force, and when an echo has ended a distance sample
// with its angle and an end-of-sweep flag.
// configuration: write i_cfg_data to register i_cfg_idx while i_cfg_we is high;
// write only while no item is in flight.
// timing: an item is taken in the idle state, then one to four phase passes
// follow; an echo end takes a single pass, then the states S_LV1, S_LV2 and
// S_LV3 let the level multiplier chain settle and S_LV3 loads the level; the
// done state then loads the output register once it is free.
// the phase sequencer handles one item at a time; the next item is taken while
// the previous result still waits in the output register.
// a stalled receiver holds the result in the output register; a finished item
// then waits until the register frees up, and input stays blocked meanwhile.
// reset loads all register defaults, puts the servo at the home level and
// starts the home wait; no result is pending after reset.
module ultrasonic_sweep_ranger (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [usr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [usr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    usr_in_if.snk                           i_item,
    usr_out_if.src                          o_res
);
    usr_pkg::t_cmd w_cmd;
    usr_pkg::t_sts w_sts;
    logic          w_in_ready;

    assign i_item.ready = w_in_ready;

    usr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    usr_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_echo     (i_item.echo_level),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_res      (o_res)
    );

endmodule

// File: sv/usr_level.sv
// three stage servo level unit: angle to duty, duty times wrap, divide by period
module usr_level (
    input  logic                         i_clk,
    input  logic                         i_home_sel,
    input  logic [usr_pkg::ANGLE_W-1:0]  i_angle,
    input  logic [usr_pkg::HDUTY_W-1:0]  i_home_duty,
    input  logic [usr_pkg::SCALE_W-1:0]  i_scale,
    input  logic [usr_pkg::WRAP_W-1:0]   i_wrap,
    output logic [usr_pkg::LEVEL_W-1:0]  o_level
);
    localparam int PROD_W = 32;
    localparam int QP_W   = PROD_W + usr_pkg::LVL_MUL_W;
    localparam int Q_W    = QP_W - usr_pkg::LVL_SHIFT;

    logic [PROD_W-1:0]           w_ang_prod;
    logic [15:0]                 n_duty;
    logic [15:0]                 r_duty;
    logic [PROD_W-1:0]           r_prod;
    logic [QP_W-1:0]             w_q_prod;
    logic [Q_W-1:0]              w_q;

    assign w_ang_prod = PROD_W'(i_angle) * PROD_W'(i_scale);
    assign n_duty     = i_home_sel ? 16'(i_home_duty) : w_ang_prod[PROD_W-1:16];

    always_ff @(posedge i_clk) begin
        r_duty <= n_duty;
        r_prod <= PROD_W'(r_duty) * PROD_W'(i_wrap);
    end

    assign w_q_prod = QP_W'(r_prod) * QP_W'(usr_pkg::LVL_MUL);
    assign w_q      = w_q_prod[QP_W-1:usr_pkg::LVL_SHIFT];
    assign o_level  = (|w_q[Q_W-1:usr_pkg::LEVEL_W]) ? '1 : w_q[usr_pkg::LEVEL_W-1:0];

endmodule

// File: sv/usr_dp.sv
// datapath: config registers, sweep state, phase step, level unit, output register
module usr_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [usr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [usr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_echo,
    input  usr_pkg::t_cmd                   i_cmd,
    output usr_pkg::t_sts                   o_sts,
    usr_out_if.src                          o_res
);
    localparam int DP_W = 19 + usr_pkg::DIST_MUL_W;

    logic [usr_pkg::STEP_W-1:0]   r_cfg_step;
    logic [usr_pkg::END_W-1:0]    r_cfg_end;
    logic [usr_pkg::SETTLE_W-1:0] r_cfg_settle;
    logic [usr_pkg::TRIG_W-1:0]   r_cfg_trig;
    logic [usr_pkg::HDUTY_W-1:0]  r_cfg_hduty;
    logic [usr_pkg::HWAIT_W-1:0]  r_cfg_hwait;
    logic [usr_pkg::SCALE_W-1:0]  r_cfg_scale;
    logic [usr_pkg::WRAP_W-1:0]   r_cfg_wrap;

    logic [2:0]                   r_phase, n_phase;
    logic [usr_pkg::WAIT_W-1:0]   r_wait, n_wait;
    logic [usr_pkg::COUNT_W-1:0]  r_echo_cnt, n_echo_cnt;
    logic [usr_pkg::ANGLE_W-1:0]  r_angle, n_angle;
    logic [usr_pkg::LEVEL_W-1:0]  r_level, n_level;
    logic                         r_lv_home, n_lv_home;
    logic                         r_echo;

    logic                         r_trig, n_trig;
    logic                         r_sv, n_sv;
    logic [usr_pkg::ANGLE_W-1:0]  r_sa, n_sa;
    logic [usr_pkg::DIST_W-1:0]   r_sd, n_sd;
    logic                         r_sl, n_sl;

    logic                         r_out_valid;
    logic                         r_o_trig;
    logic [usr_pkg::LEVEL_W-1:0]  r_o_level;
    logic                         r_o_sv;
    logic [usr_pkg::ANGLE_W-1:0]  r_o_angle;
    logic [usr_pkg::DIST_W-1:0]   r_o_dist;
    logic                         r_o_last;

    logic                         w_done;
    logic                         w_lv_req;
    logic [usr_pkg::ANGLE_W:0]    w_next;
    logic [DP_W-1:0]              w_dist_prod;
    logic [usr_pkg::LEVEL_W-1:0]  w_lv_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_step   <= usr_pkg::STEP_W'(usr_pkg::STEP_RST);
            r_cfg_end    <= usr_pkg::END_W'(usr_pkg::END_RST);
            r_cfg_settle <= usr_pkg::SETTLE_W'(usr_pkg::SETTLE_RST);
            r_cfg_trig   <= usr_pkg::TRIG_W'(usr_pkg::TRIG_RST);
            r_cfg_hduty  <= usr_pkg::HDUTY_W'(usr_pkg::HDUTY_RST);
            r_cfg_hwait  <= usr_pkg::HWAIT_W'(usr_pkg::HWAIT_RST);
            r_cfg_scale  <= usr_pkg::SCALE_W'(usr_pkg::SCALE_RST);
            r_cfg_wrap   <= usr_pkg::WRAP_W'(usr_pkg::WRAP_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                usr_pkg::CFG_ANGLE_STEP: r_cfg_step   <= i_cfg_data[usr_pkg::STEP_W-1:0];
                usr_pkg::CFG_SWEEP_END:  r_cfg_end    <= i_cfg_data[usr_pkg::END_W-1:0];
                usr_pkg::CFG_SETTLE:     r_cfg_settle <= i_cfg_data[usr_pkg::SETTLE_W-1:0];
                usr_pkg::CFG_TRIGGER:    r_cfg_trig   <= i_cfg_data[usr_pkg::TRIG_W-1:0];
                usr_pkg::CFG_HOME_DUTY:  r_cfg_hduty  <= i_cfg_data[usr_pkg::HDUTY_W-1:0];
                usr_pkg::CFG_HOME_WAIT:  r_cfg_hwait  <= i_cfg_data[usr_pkg::HWAIT_W-1:0];
                usr_pkg::CFG_DUTY_SCALE: r_cfg_scale  <= i_cfg_data[usr_pkg::SCALE_W-1:0];
                usr_pkg::CFG_PWM_WRAP:   r_cfg_wrap   <= i_cfg_data[usr_pkg::WRAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_next      = (usr_pkg::ANGLE_W+1)'(r_angle) + (usr_pkg::ANGLE_W+1)'(r_cfg_step);
    assign w_dist_prod = DP_W'({r_echo_cnt, 3'b000}) * DP_W'(usr_pkg::DIST_MUL);

    // one pass of the phase sequence
    always_comb begin
        n_phase    = r_phase;
        n_wait     = r_wait;
        n_echo_cnt = r_echo_cnt;
        n_angle    = r_angle;
        n_level    = r_level;
        n_lv_home  = r_lv_home;
        n_trig     = r_trig;
        n_sv       = r_sv;
        n_sa       = r_sa;
        n_sd       = r_sd;
        n_sl       = r_sl;
        w_done     = 1'b1;
        w_lv_req   = 1'b0;
        case (r_phase)
            usr_pkg::PH_SETTLE: begin
                if (r_wait < usr_pkg::WAIT_W'(r_cfg_settle)) begin
                    n_wait = r_wait + 1'b1;
                end else begin
                    n_phase = usr_pkg::PH_TRIG;
                    n_wait  = '0;
                    w_done  = 1'b0;
                end
            end
            usr_pkg::PH_TRIG: begin
                if (r_wait < usr_pkg::WAIT_W'(r_cfg_trig)) begin
                    n_wait = r_wait + 1'b1;
                    n_trig = 1'b1;
                end else begin
                    n_phase = usr_pkg::PH_RISE;
                    n_wait  = '0;
                    w_done  = 1'b0;
                end
            end
            usr_pkg::PH_RISE: begin
                if (r_echo) begin
                    n_echo_cnt = usr_pkg::COUNT_W'(1);
                    n_phase    = usr_pkg::PH_COUNT;
                end
            end
            usr_pkg::PH_COUNT: begin
                if (r_echo) begin
                    if (r_echo_cnt != '1) begin
                        n_echo_cnt = r_echo_cnt + 1'b1;
                    end
                end else begin
                    n_sv       = 1'b1;
                    n_sa       = r_angle;
                    n_sd       = w_dist_prod[DP_W-1:usr_pkg::DIST_SHIFT];
                    n_echo_cnt = '0;
                    n_wait     = '0;
                    w_lv_req   = 1'b1;
                    if (w_next >= (usr_pkg::ANGLE_W+1)'(r_cfg_end)) begin
                        n_sl      = 1'b1;
                        n_angle   = '0;
                        n_lv_home = 1'b1;
                        n_phase   = usr_pkg::PH_HOME;
                    end else begin
                        n_angle   = w_next[usr_pkg::ANGLE_W-1:0];
                        n_lv_home = 1'b0;
                        n_phase   = usr_pkg::PH_SETTLE;
                    end
                end
            end
            default: begin
                if (r_wait < usr_pkg::WAIT_W'(r_cfg_hwait)) begin
                    n_wait = r_wait + 1'b1;
                end else if (r_cfg_end == '0) begin
                    n_phase = usr_pkg::PH_HOME;
                    n_wait  = '0;
                end else begin
                    n_phase    = usr_pkg::PH_SETTLE;
                    n_wait     = '0;
                    n_angle    = '0;
                    n_echo_cnt = '0;
                    n_level    = '0;
                    w_done     = 1'b0;
                end
            end
        endcase
    end

    usr_level u_level (
        .i_clk       (i_clk),
        .i_home_sel  (r_lv_home),
        .i_angle     (r_angle),
        .i_home_duty (r_cfg_hduty),
        .i_scale     (r_cfg_scale),
        .i_wrap      (r_cfg_wrap),
        .o_level     (w_lv_level)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= usr_pkg::PH_HOME;
            r_wait     <= '0;
            r_echo_cnt <= '0;
            r_angle    <= '0;
            r_level    <= usr_pkg::HOME_LEVEL_RST;
            r_lv_home  <= 1'b0;
        end else if (i_cmd.eval) begin
            r_phase    <= n_phase;
            r_wait     <= n_wait;
            r_echo_cnt <= n_echo_cnt;
            r_angle    <= n_angle;
            r_level    <= n_level;
            r_lv_home  <= n_lv_home;
        end else if (i_cmd.lv_load) begin
            r_level    <= w_lv_level;
        end
    end

    // per item result, cleared when the item is taken; the echo sample is captured then
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_echo <= i_echo;
            r_trig <= 1'b0;
            r_sv   <= 1'b0;
            r_sa   <= '0;
            r_sd   <= '0;
            r_sl   <= 1'b0;
        end else if (i_cmd.eval) begin
            r_trig <= n_trig;
            r_sv   <= n_sv;
            r_sa   <= n_sa;
            r_sd   <= n_sd;
            r_sl   <= n_sl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_trig  <= r_trig;
            r_o_level <= r_level;
            r_o_sv    <= r_sv;
            r_o_angle <= r_sa;
            r_o_dist  <= r_sd;
            r_o_last  <= r_sl;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.trigger_out  = r_o_trig;
    assign o_res.pwm_level    = r_o_level;
    assign o_res.sample_valid = r_o_sv;
    assign o_res.angle_q8     = r_o_angle;
    assign o_res.distance_q4  = r_o_dist;
    assign o_res.sweep_last   = r_o_last;

    assign o_sts.done     = w_done;
    assign o_sts.lv_req   = w_lv_req;
    assign o_sts.out_free = !r_out_valid || o_res.ready;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || o_res.ready))
        else $error("output register loaded while a result waits");

    a_last_is_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_last) |-> r_o_sv)
        else $error("sweep end flagged without a sample");

    a_echo_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.eval && r_phase == usr_pkg::PH_COUNT && r_echo && r_echo_cnt == '1)
        |=> (r_echo_cnt == '1))
        else $error("echo count wrapped");

endmodule

// File: sv/usr_ctrl.sv
// controller: sequences accept, phase passes, level update and result hand-off
module usr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  usr_pkg::t_sts i_sts,
    output usr_pkg::t_cmd o_cmd
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EVAL = 6'b000010,
        S_LV1  = 6'b000100,
        S_LV2  = 6'b001000,
        S_LV3  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_sts.done) begin
                    n_state = i_sts.lv_req ? S_LV1 : S_DONE;
                end
            end
            S_LV1: begin
                n_state = S_LV2;
            end
            S_LV2: begin
                n_state = S_LV3;
            end
            S_LV3: begin
                o_cmd.lv_load = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_eval_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && $past(r_state == S_EVAL) && $past(r_state == S_EVAL, 2)
         && $past(r_state == S_EVAL, 3)) |-> i_sts.done)
        else $error("phase sequence ran past four passes");

    a_level_requested: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LV1) |-> $past(i_sts.lv_req && i_sts.done))
        else $error("level update without a servo move");

endmodule
